/* src/gbn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the Go-Back-N sender
// Opcodes, send kinds, configuration indexes and the command record that
// travels from the classifier to the send sequencer.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 11;
  localparam int WIN_W     = 7;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_W     = 16;

  // longest payload a data packet may carry
  localparam int MAX_CHUNK = 1400;

  localparam logic [WIN_W-1:0]     WINDOW_RESET  = 7'd64;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

  // configuration register indexes
  localparam logic CFG_WINDOW  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CHUNK = 2'd1,
    OP_END   = 2'd2,
    OP_ACK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RESEND = 2'd2,
    KIND_FIN    = 2'd3
  } send_kind_t;

  typedef enum logic {
    F_IDLE,
    F_EVAL
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // one request for the send sequencer; end_seq bounds a resend run
  typedef struct packed {
    send_kind_t             kind;
    logic [SEQ_W-1:0]       seq;
    logic [SEQ_W-1:0]       end_seq;
    logic [LEN_W-1:0]       len;
    logic [SEQ_W-1:0]       stamp;
    logic                   done;
  } cmd_t;

endpackage

/* src/gbn_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gbn_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_queue: two-entry command queue
// Decouples the classifier from the send sequencer.
// ----------------------------------------------------------------------------
module gbn_queue #(
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gbn_pkg::cmd_t      push_cmd,
  input  logic [IDX_W-1:0]   push_idx,
  input  logic               pop,
  output gbn_pkg::cmd_t      pop_cmd,
  output logic [IDX_W-1:0]   pop_idx,
  output logic               empty,
  output logic               full
);

  import gbn_pkg::*;

  cmd_t             cmd_mem [2];
  logic [IDX_W-1:0] idx_mem [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = cmd_mem[rd_ptr_r];
  assign pop_idx = idx_mem[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr_r] <= push_cmd;
      idx_mem[wr_ptr_r] <= push_idx;
    end
  end

endmodule

/* src/gbn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_front: request classifier and window bookkeeping
// Takes one request, checks window, timeout and fin state, updates the
// sequence bookkeeping and queues one command for the send sequencer.
// ----------------------------------------------------------------------------
module gbn_front #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               accept,
  input  logic [1:0]                                         in_opcode,
  input  logic [gbn_pkg::LEN_W-1:0]                          in_chunk_len,
  input  logic [gbn_pkg::SEQ_W-1:0]                          in_ack_seq,
  input  logic                                               cfg_we,
  input  logic                                               cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]                          cfg_wdata,
  output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] st_raddr,
  input  logic [gbn_pkg::SEQ_W-1:0]                          st_rdata,
  input  logic                                               q_full,
  output logic                                               push,
  output gbn_pkg::cmd_t                                      cmd,
  output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] cmd_idx,
  output logic                                               busy
);

  import gbn_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int EW = (CW > WIN_W) ? CW : WIN_W;
  localparam int SW = CW + 1;

  front_state_t         state_r, state_nxt;
  opcode_t              op_r, op_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [SEQ_W-1:0]     ack_r, ack_nxt;
  logic [WIN_W-1:0]     window_r, window_nxt;
  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic [AW-1:0]        base_idx_r, base_idx_nxt;
  logic [AW-1:0]        next_idx_r, next_idx_nxt;
  logic [SEQ_W-1:0]     tick_r, tick_nxt;
  logic                 ended_r, ended_nxt;
  logic [SEQ_W-1:0]     fin_time_r, fin_time_nxt;
  logic                 fin_done_r, fin_done_nxt;

  logic [SEQ_W-1:0]     n_w;
  logic [CW-1:0]        n;
  logic [EW-1:0]        w_ext;
  logic [EW-1:0]        eff;
  logic                 fin_phase;
  logic                 timed_out;
  logic                 fin_timed_out;
  logic [SEQ_W-1:0]     off_w;
  logic                 off_lt;
  logic [SW-1:0]        jump_sum;
  logic [AW-1:0]        jump_idx;
  logic [AW-1:0]        next_idx_inc;
  logic [LEN_W-1:0]     len_sat;

  assign busy     = (state_r != F_IDLE);
  assign st_raddr = base_idx_r;

  // window occupancy and derived checks
  always_comb begin
    n_w           = next_r - base_r;
    n             = n_w[CW-1:0];
    w_ext         = EW'(window_r);
    if (w_ext == '0) begin
      eff = EW'(1);
    end else if (w_ext > EW'(WINDOW_DEPTH)) begin
      eff = EW'(WINDOW_DEPTH);
    end else begin
      eff = w_ext;
    end
    fin_phase     = ended_r && (n == '0) && !fin_done_r;
    timed_out     = (tick_r - st_rdata) >= SEQ_W'(timeout_r);
    fin_timed_out = (tick_r - fin_time_r) >= SEQ_W'(timeout_r);
    off_w         = ack_r - base_r;
    off_lt        = off_w < (SEQ_W'(n) - SEQ_W'(1));
    jump_sum      = SW'(base_idx_r) + SW'(off_w[CW-1:0]) + SW'(1);
    if (jump_sum >= SW'(WINDOW_DEPTH)) begin
      jump_idx = AW'(jump_sum - SW'(WINDOW_DEPTH));
    end else begin
      jump_idx = jump_sum[AW-1:0];
    end
    next_idx_inc  = (next_idx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : next_idx_r + AW'(1);
    len_sat       = (32'(len_r) > MAX_CHUNK) ? LEN_W'(MAX_CHUNK) : len_r;
  end

  // configuration writes
  always_comb begin
    window_nxt  = window_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW:  window_nxt  = cfg_wdata[WIN_W-1:0];
        CFG_TIMEOUT: timeout_nxt = cfg_wdata[TIMEOUT_W-1:0];
        default:     window_nxt  = window_r;
      endcase
    end
  end

  // classify the request and update the bookkeeping
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    len_nxt      = len_r;
    ack_nxt      = ack_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    base_idx_nxt = base_idx_r;
    next_idx_nxt = next_idx_r;
    tick_nxt     = tick_r;
    ended_nxt    = ended_r;
    fin_time_nxt = fin_time_r;
    fin_done_nxt = fin_done_r;
    push         = 1'b0;
    cmd          = '0;
    cmd_idx      = base_idx_r;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_EVAL;
          op_nxt    = opcode_t'(in_opcode);
          len_nxt   = in_chunk_len;
          ack_nxt   = in_ack_seq;
          if (in_opcode == OP_TICK) begin
            tick_nxt = tick_r + SEQ_W'(1);
          end
        end
      end
      F_EVAL: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
          cmd.kind  = KIND_NONE;
          unique case (op_r)
            OP_TICK: begin
              if (n != '0) begin
                if (timed_out) begin
                  cmd.kind    = KIND_RESEND;
                  cmd.seq     = base_r;
                  cmd.end_seq = next_r;
                  cmd.stamp   = tick_r;
                  cmd_idx     = base_idx_r;
                end
              end else if (fin_phase && fin_timed_out) begin
                fin_time_nxt = tick_r;
                cmd.kind     = KIND_FIN;
                cmd.seq      = next_r;
              end
            end
            OP_CHUNK: begin
              if (!ended_r && (EW'(n) < eff)) begin
                cmd.kind     = KIND_NEW;
                cmd.seq      = next_r;
                cmd.len      = len_sat;
                cmd.stamp    = tick_r;
                cmd_idx      = next_idx_r;
                next_nxt     = next_r + SEQ_W'(1);
                next_idx_nxt = next_idx_inc;
              end
            end
            OP_END: begin
              if (!ended_r) begin
                ended_nxt = 1'b1;
                if ((n == '0) && !fin_done_r) begin
                  fin_time_nxt = tick_r;
                  cmd.kind     = KIND_FIN;
                  cmd.seq      = next_r;
                end
              end
            end
            OP_ACK: begin
              if (fin_phase) begin
                if (ack_r == next_r) begin
                  fin_done_nxt = 1'b1;
                end
              end else if ((n != '0) && (ack_r >= base_r)) begin
                if (off_lt) begin
                  base_nxt     = ack_r + SEQ_W'(1);
                  base_idx_nxt = jump_idx;
                end else begin
                  base_nxt     = next_r;
                  base_idx_nxt = next_idx_r;
                  if (ended_r) begin
                    fin_time_nxt = tick_r;
                    cmd.kind     = KIND_FIN;
                    cmd.seq      = next_r;
                  end
                end
              end
            end
            default: cmd.kind = KIND_NONE;
          endcase
          cmd.done = fin_done_nxt;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      window_r   <= WINDOW_RESET;
      timeout_r  <= TIMEOUT_RESET;
      base_r     <= '0;
      next_r     <= '0;
      base_idx_r <= '0;
      next_idx_r <= '0;
      tick_r     <= '0;
      ended_r    <= 1'b0;
      fin_time_r <= '0;
      fin_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      window_r   <= window_nxt;
      timeout_r  <= timeout_nxt;
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      base_idx_r <= base_idx_nxt;
      next_idx_r <= next_idx_nxt;
      tick_r     <= tick_nxt;
      ended_r    <= ended_nxt;
      fin_time_r <= fin_time_nxt;
      fin_done_r <= fin_done_nxt;
    end
  end

  // hold the request fields
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    len_r <= len_nxt;
    ack_r <= ack_nxt;
  end

endmodule

/* src/gbn_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_back: send sequencer
// Pops commands, writes slot length and send time, walks a resend run one
// slot per cycle and drives the result strobe and fields.
// ----------------------------------------------------------------------------
module gbn_back #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               q_empty,
  input  gbn_pkg::cmd_t                                      cmd,
  input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] cmd_idx,
  output logic                                               pop,
  output logic                                               st_we,
  output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] st_waddr,
  output logic [gbn_pkg::SEQ_W-1:0]                          st_wdata,
  output logic                                               out_valid,
  output logic [1:0]                                         out_send_kind,
  output logic [gbn_pkg::SEQ_W-1:0]                          out_send_seq,
  output logic [gbn_pkg::LEN_W-1:0]                          out_send_len,
  output logic                                               out_chunk_taken,
  output logic                                               out_all_done,
  output logic                                               out_last_of_run,
  output logic                                               busy
);

  import gbn_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  back_state_t      state_r, state_nxt;
  logic [SEQ_W-1:0] cur_seq_r, cur_seq_nxt;
  logic [SEQ_W-1:0] end_seq_r, end_seq_nxt;
  logic [AW-1:0]    cur_idx_r, cur_idx_nxt;
  logic [SEQ_W-1:0] stamp_r, stamp_nxt;

  logic             p_valid_r, p_valid_nxt;
  send_kind_t       p_kind_r, p_kind_nxt;
  logic [SEQ_W-1:0] p_seq_r, p_seq_nxt;
  logic [LEN_W-1:0] p_len_r, p_len_nxt;
  logic             p_ram_r, p_ram_nxt;
  logic             p_taken_r, p_taken_nxt;
  logic             p_last_r, p_last_nxt;
  logic             p_done_r, p_done_nxt;

  logic             len_we;
  logic [LEN_W-1:0] len_rdata;
  logic [AW-1:0]    cur_idx_inc;
  logic             run_last;

  gbn_ram #(
    .WIDTH (LEN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (cmd_idx),
    .wdata (cmd.len),
    .raddr (cur_idx_r),
    .rdata (len_rdata)
  );

  assign busy            = (state_r != B_IDLE) || p_valid_r;
  assign out_valid       = p_valid_r;
  assign out_send_kind   = p_kind_r;
  assign out_send_seq    = p_seq_r;
  assign out_send_len    = p_ram_r ? len_rdata : p_len_r;
  assign out_chunk_taken = p_taken_r;
  assign out_all_done    = p_done_r;
  assign out_last_of_run = p_last_r;

  assign cur_idx_inc = (cur_idx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : cur_idx_r + AW'(1);
  assign run_last    = ((cur_seq_r + SEQ_W'(1)) == end_seq_r);

  // pop commands and sequence the sends
  always_comb begin
    state_nxt   = state_r;
    cur_seq_nxt = cur_seq_r;
    end_seq_nxt = end_seq_r;
    cur_idx_nxt = cur_idx_r;
    stamp_nxt   = stamp_r;
    p_valid_nxt = 1'b0;
    p_kind_nxt  = p_kind_r;
    p_seq_nxt   = p_seq_r;
    p_len_nxt   = p_len_r;
    p_ram_nxt   = p_ram_r;
    p_taken_nxt = p_taken_r;
    p_last_nxt  = p_last_r;
    p_done_nxt  = p_done_r;
    pop         = 1'b0;
    len_we      = 1'b0;
    st_we       = 1'b0;
    st_waddr    = cur_idx_r;
    st_wdata    = stamp_r;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop         = 1'b1;
          p_done_nxt  = cmd.done;
          p_taken_nxt = 1'b0;
          p_ram_nxt   = 1'b0;
          p_last_nxt  = 1'b1;
          p_kind_nxt  = cmd.kind;
          p_seq_nxt   = '0;
          p_len_nxt   = '0;
          unique case (cmd.kind)
            KIND_RESEND: begin
              state_nxt   = B_RUN;
              cur_seq_nxt = cmd.seq;
              end_seq_nxt = cmd.end_seq;
              cur_idx_nxt = cmd_idx;
              stamp_nxt   = cmd.stamp;
            end
            KIND_NEW: begin
              len_we      = 1'b1;
              st_we       = 1'b1;
              st_waddr    = cmd_idx;
              st_wdata    = cmd.stamp;
              p_valid_nxt = 1'b1;
              p_seq_nxt   = cmd.seq;
              p_len_nxt   = cmd.len;
              p_taken_nxt = 1'b1;
            end
            KIND_FIN: begin
              p_valid_nxt = 1'b1;
              p_seq_nxt   = cmd.seq;
            end
            KIND_NONE: begin
              p_valid_nxt = 1'b1;
            end
            default: p_valid_nxt = 1'b1;
          endcase
        end
      end
      B_RUN: begin
        // restamp one slot and send it again
        st_we       = 1'b1;
        p_valid_nxt = 1'b1;
        p_kind_nxt  = KIND_RESEND;
        p_seq_nxt   = cur_seq_r;
        p_ram_nxt   = 1'b1;
        p_taken_nxt = 1'b0;
        p_last_nxt  = run_last;
        cur_seq_nxt = cur_seq_r + SEQ_W'(1);
        cur_idx_nxt = cur_idx_inc;
        if (run_last) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      p_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  // run position and result payload
  always_ff @(posedge clk) begin
    cur_seq_r <= cur_seq_nxt;
    end_seq_r <= end_seq_nxt;
    cur_idx_r <= cur_idx_nxt;
    stamp_r   <= stamp_nxt;
    p_kind_r  <= p_kind_nxt;
    p_seq_r   <= p_seq_nxt;
    p_len_r   <= p_len_nxt;
    p_ram_r   <= p_ram_nxt;
    p_taken_r <= p_taken_nxt;
    p_last_r  <= p_last_nxt;
    p_done_r  <= p_done_nxt;
  end

endmodule

/* src/go_back_n_sender_top.sv */
`timescale 1ns / 1ps
// Flow: an accepted request is held in the front's evaluation state, then queued as a command,
// popped by the sequencer and registered as a result; a resend run gives its results on
// consecutive cycles. A new request is taken only once the previous one is fully through;
// results cannot be stalled and each strobe lasts one cycle.
// Reset (rst_n low, synchronous) clears sequence state, tick count, fin state and
// sets window 64, timeout 200; slot memories need no clearing.
// ----------------------------------------------------------------------------
// go_back_n_sender_top: Go-Back-N sender control
// Classifier front, two-entry command queue, send sequencer back and the
// slot send-time memory shared between them.
// ----------------------------------------------------------------------------
module go_back_n_sender_top #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_opcode,
  input  logic [gbn_pkg::LEN_W-1:0]    in_chunk_len,
  input  logic [gbn_pkg::SEQ_W-1:0]    in_ack_seq,
  output logic                         out_valid,
  output logic [1:0]                   out_send_kind,
  output logic [gbn_pkg::SEQ_W-1:0]    out_send_seq,
  output logic [gbn_pkg::LEN_W-1:0]    out_send_len,
  output logic                         out_chunk_taken,
  output logic                         out_all_done,
  output logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]    cfg_wdata
);

  import gbn_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic             accept;
  logic             front_busy;
  logic             back_busy;
  logic [AW-1:0]    st_raddr;
  logic [SEQ_W-1:0] st_rdata;
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [SEQ_W-1:0] st_wdata;
  logic             q_push, q_pop, q_empty, q_full;
  cmd_t             push_cmd, pop_cmd;
  logic [AW-1:0]    push_idx, pop_idx;

  // one request in flight at a time
  assign busy   = front_busy || !q_empty || back_busy;
  assign accept = start && !busy;

  gbn_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_opcode    (in_opcode),
    .in_chunk_len (in_chunk_len),
    .in_ack_seq   (in_ack_seq),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .q_full       (q_full),
    .push         (q_push),
    .cmd          (push_cmd),
    .cmd_idx      (push_idx),
    .busy         (front_busy)
  );

  gbn_queue #(
    .IDX_W (AW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .push_idx (push_idx),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .pop_idx  (pop_idx),
    .empty    (q_empty),
    .full     (q_full)
  );

  // slot send times: stamped by the sequencer, oldest slot read by the front
  gbn_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  gbn_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .cmd             (pop_cmd),
    .cmd_idx         (pop_idx),
    .pop             (q_pop),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .out_valid       (out_valid),
    .out_send_kind   (out_send_kind),
    .out_send_seq    (out_send_seq),
    .out_send_len    (out_send_len),
    .out_chunk_taken (out_chunk_taken),
    .out_all_done    (out_all_done),
    .out_last_of_run (out_last_of_run),
    .busy            (back_busy)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after an accepted request");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |=> !out_valid)
    else $error("result after the last of a run");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_send_kind == KIND_NONE) |-> out_last_of_run)
    else $error("empty result not last of run");

  a_taken_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_taken |-> (out_send_kind == KIND_NEW) && out_last_of_run)
    else $error("chunk taken on a result that is not a single new send");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for go_back_n_sender_top
// Drives tick, chunk, end-of-data and ack requests through the start/busy
// port and keeps its own model of the sender's window, timers and fin state.
// Every result strobe is checked field by field against the oldest expected
// send. The run covers corner cases first, then random traffic in three
// sender-gap profiles, and ends with the fin handshake and the completed state.
// ----------------------------------------------------------------------------
module testbench;
  import gbn_pkg::*;

  localparam int WIN_DEPTH = 64;

  typedef struct {
    send_kind_t       kind;
    bit [SEQ_W-1:0]   seq;
    bit [LEN_W-1:0]   len;
    bit               taken;
    bit               done;
    bit               last;
  } send_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  opcode_t              in_opcode = OP_TICK;
  logic [LEN_W-1:0]     in_chunk_len = '0;
  logic [SEQ_W-1:0]     in_ack_seq = '0;
  logic                 out_valid;
  logic [1:0]           out_send_kind;
  logic [SEQ_W-1:0]     out_send_seq;
  logic [LEN_W-1:0]     out_send_len;
  logic                 out_chunk_taken;
  logic                 out_all_done;
  logic                 out_last_of_run;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // sender model state
  bit [WIN_W-1:0]       win_reg = WINDOW_RESET;
  bit [TIMEOUT_W-1:0]   rto_reg = TIMEOUT_RESET;
  bit [SEQ_W-1:0]       una_seq = '0;
  bit [SEQ_W-1:0]       nxt_seq = '0;
  bit [SEQ_W-1:0]       tick_cnt = '0;
  bit [SEQ_W-1:0]       fin_stamp = '0;
  bit                   eod_seen = 1'b0;
  bit                   fin_closed = 1'b0;
  bit [LEN_W-1:0]       slot_len [WIN_DEPTH];
  bit [SEQ_W-1:0]       slot_stamp [WIN_DEPTH];

  send_rec_t            sends_due [$];
  int                   mismatches = 0;

  go_back_n_sender_top #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_chunk_len   (in_chunk_len),
    .in_ack_seq     (in_ack_seq),
    .out_valid      (out_valid),
    .out_send_kind  (out_send_kind),
    .out_send_seq   (out_send_seq),
    .out_send_len   (out_send_len),
    .out_chunk_taken(out_chunk_taken),
    .out_all_done   (out_all_done),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit [SEQ_W-1:0] in_flight();
    return nxt_seq - una_seq;
  endfunction

  function automatic bit fin_pending();
    return eod_seen && (nxt_seq == una_seq) && !fin_closed;
  endfunction

  // clamp the window register into 1..WIN_DEPTH
  function automatic bit [SEQ_W-1:0] eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > WIN_DEPTH) return WIN_DEPTH;
    return win_reg;
  endfunction

  function automatic send_rec_t make_send(send_kind_t kind, bit [SEQ_W-1:0] seq,
                                          bit [LEN_W-1:0] len, bit taken);
    send_rec_t r;
    r.kind  = kind;
    r.seq   = seq;
    r.len   = len;
    r.taken = taken;
    r.done  = fin_closed;
    r.last  = 1'b0;
    return r;
  endfunction

  // advance the model by one request and queue the sends it causes
  task automatic predict_sends(opcode_t op, bit [LEN_W-1:0] clen, bit [SEQ_W-1:0] ack);
    send_rec_t       run [$];
    bit [SEQ_W-1:0]  n;
    bit [SEQ_W-1:0]  seq;
    bit [LEN_W-1:0]  len;
    case (op)
      OP_TICK: begin
        tick_cnt++;
        n = in_flight();
        if (n != 0 && n <= WIN_DEPTH) begin
          if (tick_cnt - slot_stamp[una_seq % WIN_DEPTH] >= rto_reg) begin
            for (bit [SEQ_W-1:0] i = 0; i < n; i++) begin
              seq = una_seq + i;
              slot_stamp[seq % WIN_DEPTH] = tick_cnt;
              run.insert(run.size(),
                         make_send(KIND_RESEND, seq, slot_len[seq % WIN_DEPTH], 1'b0));
            end
          end
        end else if (fin_pending()) begin
          if (tick_cnt - fin_stamp >= rto_reg) begin
            fin_stamp = tick_cnt;
            run.insert(run.size(), make_send(KIND_FIN, nxt_seq, '0, 1'b0));
          end
        end
      end
      OP_CHUNK: begin
        if (!eod_seen && in_flight() < eff_window()) begin
          len = (clen > MAX_CHUNK) ? LEN_W'(MAX_CHUNK) : clen;
          slot_len[nxt_seq % WIN_DEPTH]   = len;
          slot_stamp[nxt_seq % WIN_DEPTH] = tick_cnt;
          run.insert(run.size(), make_send(KIND_NEW, nxt_seq, len, 1'b1));
          nxt_seq++;
        end
      end
      OP_END: begin
        if (!eod_seen) begin
          eod_seen = 1'b1;
          if (fin_pending()) begin
            fin_stamp = tick_cnt;
            run.insert(run.size(), make_send(KIND_FIN, nxt_seq, '0, 1'b0));
          end
        end
      end
      default: begin
        n = in_flight();
        if (fin_pending()) begin
          if (ack == nxt_seq) fin_closed = 1'b1;
        end else if (n != 0 && ack >= una_seq) begin
          // cumulative ack: free every slot up to it
          if (ack - una_seq < n - 1) una_seq = ack + 1;
          else una_seq = nxt_seq;
          if (fin_pending()) begin
            fin_stamp = tick_cnt;
            run.insert(run.size(), make_send(KIND_FIN, nxt_seq, '0, 1'b0));
          end
        end
      end
    endcase
    if (run.size() == 0) run.insert(0, make_send(KIND_NONE, '0, '0, 1'b0));
    run[run.size() - 1].last = 1'b1;
    foreach (run[k]) sends_due.insert(sends_due.size(), run[k]);
  endtask

  // drive one request and hold it until the block takes it
  task automatic send_request(opcode_t op, bit [LEN_W-1:0] clen, bit [SEQ_W-1:0] ack);
    @(negedge clk);
    start        <= 1'b1;
    in_opcode    <= op;
    in_chunk_len <= clen;
    in_ack_seq   <= ack;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    predict_sends(op, clen, ack);
  endtask

  task automatic write_reg(logic idx, bit [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW) win_reg = val[WIN_W-1:0];
    else rto_reg = val[TIMEOUT_W-1:0];
  endtask

  // wait for every expected send, then let the back end go quiet
  task automatic settle();
    while (sends_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic bit [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return LEN_W'(MAX_CHUNK);
    if (r < 30) return LEN_W'($urandom_range(MAX_CHUNK + 1, 2047));
    return LEN_W'($urandom_range(1, MAX_CHUNK - 1));
  endfunction

  // mostly acks inside the window, some stale, some beyond, some noise
  function automatic bit [SEQ_W-1:0] pick_ack();
    bit [SEQ_W-1:0] n;
    int unsigned    r;
    n = in_flight();
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 20) return una_seq - $urandom_range(1, 3);
    if (r < 30 || n == 0) return nxt_seq + $urandom_range(0, 4);
    return una_seq + $urandom_range(0, n - 1);
  endfunction

  task automatic test_special_cases();
    // window 0 acts as one slot; short timeout
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd10);
    send_request(OP_CHUNK, '0, $urandom);
    send_request(OP_CHUNK, 11'h7FF, '0);
    send_request(OP_ACK, $urandom, '0);
    send_request(OP_CHUNK, 11'h7FF, 32'hFFFF_FFFF);
    repeat (10) send_request(OP_TICK, '0, '0);
    settle();
    // window above depth acts as full depth; longest timeout
    write_reg(CFG_WINDOW, 16'd127);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_request(OP_CHUNK, LEN_W'(MAX_CHUNK), $urandom);
    send_request(OP_CHUNK, LEN_W'(MAX_CHUNK + 1), $urandom);
    send_request(OP_CHUNK, 11'd5, $urandom);
    send_request(OP_ACK, 11'h7FF, una_seq - 1);
    send_request(OP_ACK, '0, una_seq + 1);
    send_request(OP_ACK, '0, 32'hFFFF_FFFF);
    send_request(OP_ACK, 11'h7FF, nxt_seq + 2);
    send_request(OP_TICK, 11'h7FF, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_random_traffic(int gap_pct, int ack_pct, bit [CFG_W-1:0] win,
                                     bit [CFG_W-1:0] rto, int count);
    int unsigned r;
    settle();
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_TIMEOUT, rto);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < gap_pct) repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then hold off until the block has drained
      if ($urandom_range(0, 39) == 0) begin
        while (sends_due.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < ack_pct) send_request(OP_ACK, $urandom, pick_ack());
      else if (r < ack_pct + 35) send_request(OP_TICK, $urandom, $urandom);
      else send_request(OP_CHUNK, pick_len(), $urandom);
    end
  endtask

  task automatic test_fin_handshake();
    bit early;
    settle();
    write_reg(CFG_TIMEOUT, 16'd10);
    early = $urandom_range(0, 1);
    send_request(OP_CHUNK, pick_len(), $urandom);
    // either empty the window first, so fin goes out with end of data
    if (early) send_request(OP_ACK, $urandom, 32'hFFFF_FFFF);
    send_request(OP_END, $urandom, $urandom);
    send_request(OP_END, $urandom, $urandom);
    send_request(OP_CHUNK, 11'd100, $urandom);
    repeat (12) send_request(OP_TICK, $urandom, $urandom);
    // or let the last ack of the data window release the fin
    if (!early) begin
      send_request(OP_ACK, $urandom, una_seq);
      send_request(OP_ACK, $urandom, 32'hFFFF_FFFF);
    end
    send_request(OP_ACK, $urandom, nxt_seq + 1);
    send_request(OP_ACK, $urandom, nxt_seq - 1);
    repeat (11) send_request(OP_TICK, $urandom, $urandom);
    send_request(OP_ACK, $urandom, nxt_seq);
    // completed: everything but ticks is ignored
    send_request(OP_TICK, $urandom, $urandom);
    send_request(OP_CHUNK, 11'd1, $urandom);
    send_request(OP_END, $urandom, $urandom);
    send_request(OP_ACK, $urandom, nxt_seq);
  endtask

  function automatic void check_field(string name, bit [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // compare each result strobe with the oldest expected send
  always @(posedge clk) begin : check_sends
    send_rec_t due;
    if (rst_n && out_valid === 1'b1) begin
      if (sends_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d seq %0h",
                 $time, out_send_kind, out_send_seq);
      end else begin
        due = sends_due[0];
        sends_due.delete(0);
        check_field("send_kind", due.kind, out_send_kind);
        check_field("send_seq", due.seq, out_send_seq);
        check_field("send_len", due.len, out_send_len);
        check_field("chunk_taken", due.taken, out_chunk_taken);
        check_field("all_done", due.done, out_all_done);
        check_field("last_of_run", due.last, out_last_of_run);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_random_traffic(28, 20, $urandom_range(1, 8), 16'd12, 110);
    test_random_traffic(80, 5, 16'd64, 16'd10, 110);
    test_random_traffic(0, 25, $urandom_range(2, 63), $urandom_range(10, 30), 110);
    test_fin_handshake();
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
